@@ sv/tpd_pkg.sv @@
`default_nettype none
package tpd_pkg;
  localparam int HIST_BINS = 512;
  localparam int BIN_W = $clog2(HIST_BINS);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(HIST_BINS - 1);
  localparam logic [15:0] TYPE_SYNC = 16'hffff;
  localparam logic [15:0] TYPE_HIST = 16'hfffe;
  localparam logic [7:0] SYNC_BYTE = 8'hff;
  localparam logic [4:0] PH_HDR_LAST = 5'd17;
  localparam logic [4:0] PH_PAY_LO = 5'd18;
  localparam logic [4:0] PH_PAY_HI = 5'd19;
  localparam int QDEPTH = 2;

  typedef enum logic {
    KIND_HDR = 1'b0,
    KIND_WORD = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [15:0] ptype;
    logic [31:0] tick;
    logic [31:0] trig;
    logic [15:0] size;
    logic [47:0] fields;
    logic [15:0] idx;
    logic [15:0] value;
    logic hist_on;
    logic seed;
    logic last;
  } job_t;

  typedef struct packed {
    logic [15:0] delta;
    logic [31:0] total;
  } upd_t;
endpackage
`default_nettype wire

@@ sv/tpd_ram.sv @@
`default_nettype none
module tpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/tpd_front.sv @@
`default_nettype none
module tpd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [7:0]    rx_byte,
  output logic               job_vld,
  output tpd_pkg::job_t      job
);
  logic synced_r, synced_nxt, pff_r, pff_nxt, first_r, first_nxt;
  logic [4:0] ph_r, ph_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [15:0] type_r, type_nxt, size_r, size_nxt, cnt_r, cnt_nxt;
  logic [31:0] tick_r, tick_nxt, trig_r, trig_nxt;
  logic [47:0] fld_r, fld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r <= 1'b0; pff_r <= 1'b0; first_r <= 1'b1; ph_r <= '0;
      lo_r <= '0; type_r <= '0; size_r <= '0; cnt_r <= '0;
      tick_r <= '0; trig_r <= '0; fld_r <= '0;
    end else begin
      synced_r <= synced_nxt; pff_r <= pff_nxt; first_r <= first_nxt; ph_r <= ph_nxt;
      lo_r <= lo_nxt; type_r <= type_nxt; size_r <= size_nxt; cnt_r <= cnt_nxt;
      tick_r <= tick_nxt; trig_r <= trig_nxt; fld_r <= fld_nxt;
    end
  end

  always_comb begin
    synced_nxt = synced_r; pff_nxt = pff_r; first_nxt = first_r; ph_nxt = ph_r;
    lo_nxt = lo_r; type_nxt = type_r; size_nxt = size_r; cnt_nxt = cnt_r;
    tick_nxt = tick_r; trig_nxt = trig_r; fld_nxt = fld_r;
    job_vld = 1'b0;
    job = '0;
    if (in_fire) begin
      if (!synced_r) begin
        if (rx_byte == tpd_pkg::SYNC_BYTE && pff_r) begin
          synced_nxt = 1'b1;
          type_nxt = tpd_pkg::TYPE_SYNC;
          ph_nxt = 5'd2;
        end
        pff_nxt = (rx_byte == tpd_pkg::SYNC_BYTE);
      end else if (ph_r <= tpd_pkg::PH_HDR_LAST) begin
        if (ph_r < 5'd2) type_nxt[ph_r[0]*8 +: 8] = rx_byte;
        else if (ph_r < 5'd6) tick_nxt[2'(ph_r - 5'd2)*8 +: 8] = rx_byte;
        else if (ph_r < 5'd10) trig_nxt[2'(ph_r - 5'd6)*8 +: 8] = rx_byte;
        else if (ph_r < 5'd12) size_nxt[1'(ph_r - 5'd10)*8 +: 8] = rx_byte;
        else fld_nxt[3'(ph_r - 5'd12)*8 +: 8] = rx_byte;
        if (ph_r < tpd_pkg::PH_HDR_LAST) begin
          ph_nxt = ph_r + 5'd1;
        end else begin
          job_vld = 1'b1;
          job.kind = tpd_pkg::KIND_HDR;
          job.ptype = type_nxt; job.tick = tick_nxt; job.trig = trig_nxt;
          job.size = size_nxt; job.fields = fld_nxt;
          cnt_nxt = '0;
          if (size_nxt == 16'd0) begin
            job.last = 1'b1;
            if (type_nxt == tpd_pkg::TYPE_HIST) first_nxt = 1'b0;
            ph_nxt = '0;
          end else begin
            ph_nxt = tpd_pkg::PH_PAY_LO;
          end
        end
      end else if (ph_r == tpd_pkg::PH_PAY_LO) begin
        lo_nxt = rx_byte;
        ph_nxt = tpd_pkg::PH_PAY_HI;
      end else begin
        job_vld = 1'b1;
        job.kind = tpd_pkg::KIND_WORD;
        job.ptype = type_r; job.tick = tick_r; job.trig = trig_r;
        job.size = size_r; job.fields = fld_r;
        job.idx = cnt_r;
        job.value = {rx_byte, lo_r};
        job.hist_on = (type_r == tpd_pkg::TYPE_HIST) && ({1'b0, cnt_r} < 17'(tpd_pkg::HIST_BINS));
        job.seed = first_r;
        job.last = ({1'b0, cnt_r} + 17'd1 >= {1'b0, size_r});
        if (job.last) begin
          if (type_r == tpd_pkg::TYPE_HIST) first_nxt = 1'b0;
          ph_nxt = '0;
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 16'd1;
          ph_nxt = tpd_pkg::PH_PAY_LO;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/tpd_queue.sv @@
`default_nettype none
module tpd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire tpd_pkg::job_t wr_job,
  output logic               full,
  output logic               rd_vld,
  input  wire logic          rd_en,
  output tpd_pkg::job_t      rd_job
);
  tpd_pkg::job_t q_r [tpd_pkg::QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = (cnt_r == 2'(tpd_pkg::QDEPTH));
  assign rd_vld = (cnt_r != 2'd0);
  assign rd_job = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr_en) q_r[wp_r] <= wr_job;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

@@ sv/tpd_back.sv @@
`default_nettype none
module tpd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_vld,
  input  wire tpd_pkg::job_t job,
  output logic               job_take,
  output logic               res_vld,
  output tpd_pkg::job_t      res_job,
  output tpd_pkg::upd_t      res_upd,
  input  wire logic          res_take
);
  // read issued as a job is taken; stage 1: update and write; stage 2: out stage
  logic s1_r, s2_r;
  tpd_pkg::job_t j1_r, j2_r;
  tpd_pkg::upd_t u2_r;
  logic clr_r;
  logic [tpd_pkg::BIN_W-1:0] clr_a_r;
  logic [15:0] prev_rd;
  logic [31:0] tot_rd;
  logic [15:0] prev_q;
  logic [31:0] tot_q;
  logic adv1, adv2, we, upd_we;
  logic [tpd_pkg::BIN_W-1:0] ra, wa;
  logic [15:0] delta, prev_wd;
  logic [31:0] tot_wd;
  logic [32:0] sum;
  tpd_pkg::upd_t u1;
  // bypass from the write stage
  logic byp_r;
  logic [15:0] byp_prev_r;
  logic [31:0] byp_tot_r;

  assign adv2 = !s2_r || res_take;
  assign adv1 = !s1_r || adv2;
  assign job_take = job_vld && adv1 && !clr_r;
  assign res_vld = s2_r;
  assign res_job = j2_r;
  assign res_upd = u2_r;
  // hold the read address while stage 1 stalls
  assign ra = adv1 ? job.idx[tpd_pkg::BIN_W-1:0] : j1_r.idx[tpd_pkg::BIN_W-1:0];
  assign wa = clr_r ? clr_a_r : j1_r.idx[tpd_pkg::BIN_W-1:0];
  assign we = clr_r || upd_we;
  assign prev_wd = clr_r ? 16'd0 : j1_r.value;
  assign tot_wd = clr_r ? 32'd0 : u1.total;

  tpd_ram #(.WIDTH(16), .DEPTH(tpd_pkg::HIST_BINS)) u_prev (
    .clk(clk), .we(we), .waddr(wa), .wdata(prev_wd), .raddr(ra), .rdata(prev_rd));
  tpd_ram #(.WIDTH(32), .DEPTH(tpd_pkg::HIST_BINS)) u_tot (
    .clk(clk), .we(we), .waddr(wa), .wdata(tot_wd), .raddr(ra), .rdata(tot_rd));

  always_comb begin
    prev_q = byp_r ? byp_prev_r : prev_rd;
    tot_q = byp_r ? byp_tot_r : tot_rd;
    delta = j1_r.value - prev_q;
    sum = {1'b0, tot_q} + {17'd0, delta};
    u1 = '0;
    upd_we = 1'b0;
    if (s1_r && j1_r.kind == tpd_pkg::KIND_WORD && j1_r.hist_on) begin
      upd_we = adv2;
      if (j1_r.seed) begin
        u1.total = tot_q;
      end else begin
        u1.delta = delta;
        u1.total = sum[32] ? 32'hffff_ffff : sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) j1_r <= job;
    if (adv2) begin
      j2_r <= j1_r;
      u2_r <= u1;
    end
    if (adv1) begin
      byp_r <= upd_we && job_take && job.kind == tpd_pkg::KIND_WORD &&
               (job.idx[tpd_pkg::BIN_W-1:0] == j1_r.idx[tpd_pkg::BIN_W-1:0]);
      byp_prev_r <= j1_r.value;
      byp_tot_r <= u1.total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0; s2_r <= 1'b0; clr_r <= 1'b1; clr_a_r <= '0;
    end else begin
      if (adv1) s1_r <= job_take;
      if (adv2) s2_r <= s1_r;
      if (clr_r) begin
        clr_a_r <= clr_a_r + 1'b1;
        if (clr_a_r == tpd_pkg::BIN_LAST) clr_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/telemetry_packet_deframer_hist_delta.sv @@
// The byte that completes a header or payload word writes a job into the queue; out_tvalid
//   rises once the job has passed the back-end registers s1_r and s2_r, when the back end is free.
// One byte per cycle while the queue is not full; the back end takes new jobs while earlier ones are in flight.
// Histogram bins live in two registered-read RAMs updated by read-modify-write.
// Synchronous active-low reset clears the parser and queue, then a pass over all 512 bin
//   addresses zeroes both bin RAMs; bytes are still taken until the queue fills, results wait.
`default_nettype none
module telemetry_packet_deframer_hist_delta (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // rx_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [223:0]      out_tdata,  // packet_type, tick, trig_time, data_size, field1,
                                        // fields_2_3, word_index, word_value,
                                        // count_delta, binned_total
  output logic              out_tuser,  // kind
  output logic              out_tlast   // last
);
  logic in_fire, fj_vld, q_full, q_vld, q_take;
  tpd_pkg::job_t fj, qj, rj;
  tpd_pkg::upd_t ru;

  assign in_tready = !q_full;
  assign in_fire = in_tvalid && in_tready;

  tpd_front u_front (.clk(clk), .rst_n(rst_n), .in_fire(in_fire), .rx_byte(in_tdata),
    .job_vld(fj_vld), .job(fj));
  tpd_queue u_queue (.clk(clk), .rst_n(rst_n), .wr_en(fj_vld), .wr_job(fj), .full(q_full),
    .rd_vld(q_vld), .rd_en(q_take), .rd_job(qj));
  tpd_back u_back (.clk(clk), .rst_n(rst_n), .job_vld(q_vld), .job(qj), .job_take(q_take),
    .res_vld(out_tvalid), .res_job(rj), .res_upd(ru), .res_take(out_tready));

  assign out_tuser = rj.kind;
  assign out_tlast = rj.last;
  assign out_tdata = {ru.total, ru.delta, rj.value, rj.idx, rj.fields, rj.size,
                      rj.trig, rj.tick, rj.ptype};

  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !in_fire)
    else $error("write into full queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tpd_pkg::KIND_HDR |-> out_tdata[223:176] == 48'd0)
    else $error("header result carries word data");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped");
endmodule
`default_nettype wire

@@ tb/telemetry_packet_deframer_hist_delta_tb.sv @@
`default_nettype none
module telemetry_packet_deframer_hist_delta_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [15:0] ptype;
    logic [31:0] tick;
    logic [31:0] trig;
    logic [15:0] size;
    logic [15:0] f1;
    logic [31:0] f23;
    logic [15:0] idx;
    logic [15:0] value;
    logic [15:0] delta;
    logic [31:0] total;
    logic        last;
  } deframed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire [223:0] out_tdata;
  wire out_tuser;
  wire out_tlast;

  telemetry_packet_deframer_hist_delta uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  logic [7:0] byte_q[$];
  deframed_t expect_q[$];
  int mismatches = 0;
  bit hold_send = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int rand_bytes = 0;

  bit         p_synced;
  bit         p_prev_ff;
  int         p_phase;
  logic [7:0] p_lo;
  logic [15:0] p_type;
  logic [31:0] p_tick;
  logic [31:0] p_trig;
  logic [15:0] p_size;
  logic [47:0] p_fields;
  logic [15:0] p_wcnt;
  bit         p_first_hist;
  logic [15:0] prev_cnt[tpd_pkg::HIST_BINS];
  logic [31:0] bin_total[tpd_pkg::HIST_BINS];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic deframed_t header_view();
    deframed_t d;
    d = '0;
    d.ptype = p_type;
    d.tick = p_tick;
    d.trig = p_trig;
    d.size = p_size;
    d.f1 = p_fields[15:0];
    d.f23 = p_fields[47:16];
    return d;
  endfunction

  task automatic enq_byte(input logic [7:0] b);
    byte_q = {byte_q, b};
  endtask

  task automatic enq_expect(input deframed_t d);
    expect_q = {expect_q, d};
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    deframed_t d;
    logic [15:0] v;
    logic [15:0] dl;
    logic [32:0] sum;
    int ix;
    if (!p_synced) begin
      if (b == tpd_pkg::SYNC_BYTE && p_prev_ff) begin
        p_synced = 1'b1;
        p_type = tpd_pkg::TYPE_SYNC;
        p_phase = 2;
      end
      p_prev_ff = (b == tpd_pkg::SYNC_BYTE);
      return;
    end
    if (p_phase <= tpd_pkg::PH_HDR_LAST) begin
      if (p_phase < 2) p_type[p_phase*8 +: 8] = b;
      else if (p_phase < 6) p_tick[(p_phase-2)*8 +: 8] = b;
      else if (p_phase < 10) p_trig[(p_phase-6)*8 +: 8] = b;
      else if (p_phase < 12) p_size[(p_phase-10)*8 +: 8] = b;
      else p_fields[(p_phase-12)*8 +: 8] = b;
      if (p_phase < tpd_pkg::PH_HDR_LAST) begin
        p_phase++;
        return;
      end
      d = header_view();
      d.kind = tpd_pkg::KIND_HDR;
      p_wcnt = '0;
      if (p_size == 0) begin
        d.last = 1'b1;
        if (p_type == tpd_pkg::TYPE_HIST) p_first_hist = 1'b0;
        p_phase = 0;
      end else begin
        p_phase = tpd_pkg::PH_PAY_LO;
      end
      enq_expect(d);
      return;
    end
    if (p_phase == tpd_pkg::PH_PAY_LO) begin
      p_lo = b;
      p_phase = tpd_pkg::PH_PAY_HI;
      return;
    end
    v = {b, p_lo};
    d = header_view();
    d.kind = tpd_pkg::KIND_WORD;
    d.idx = p_wcnt;
    d.value = v;
    d.last = ({16'h0, p_wcnt} + 32'd1 >= {16'h0, p_size});
    if (p_type == tpd_pkg::TYPE_HIST && p_wcnt < tpd_pkg::HIST_BINS) begin
      ix = int'(p_wcnt);
      if (!p_first_hist) begin
        dl = v - prev_cnt[ix];
        sum = {1'b0, bin_total[ix]} + {17'd0, dl};
        bin_total[ix] = sum[32] ? 32'hffffffff : sum[31:0];
        d.delta = dl;
      end
      prev_cnt[ix] = v;
      d.total = bin_total[ix];
    end
    if (d.last) begin
      if (p_type == tpd_pkg::TYPE_HIST) p_first_hist = 1'b0;
      p_phase = 0;
      p_wcnt = '0;
    end else begin
      p_wcnt = p_wcnt + 16'd1;
      p_phase = tpd_pkg::PH_PAY_LO;
    end
    enq_expect(d);
  endtask

  task automatic push_packet(input logic [15:0] ty, input bit with_type, input logic [15:0] n,
                             input int mode);
    logic [15:0] w;
    if (with_type) begin
      enq_byte(ty[7:0]);
      enq_byte(ty[15:8]);
    end
    repeat (4) enq_byte(8'($urandom));
    repeat (4) enq_byte(8'($urandom));
    enq_byte(n[7:0]);
    enq_byte(n[15:8]);
    repeat (6) enq_byte(8'($urandom));
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = 16'($urandom);
        1: w = 16'hffff;
        2: w = 16'h0000;
        default: w = 16'($urandom_range(0, 40) * i);
      endcase
      enq_byte(w[7:0]);
      enq_byte(w[15:8]);
    end
  endtask

  task automatic push_bytes(input logic [7:0] b, input int n);
    repeat (n) enq_byte(b);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        rand_bytes++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!hold_send && byte_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_q.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    deframed_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '0;
        {got.total, got.delta, got.value, got.idx, got.f23, got.f1, got.size,
         got.trig, got.tick, got.ptype} = out_tdata;
        got.kind = out_tuser;
        got.last = out_tlast;
        if (expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %h", got);
        end else begin
          want = expect_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch kind %0d idx %0d", want.kind, want.idx);
              $display("  expected %h", want);
              $display("  actual   %h", got);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  initial begin
    p_synced = 0; p_prev_ff = 0; p_phase = 0; p_lo = 0; p_type = 0; p_tick = 0;
    p_trig = 0; p_size = 0; p_fields = 0; p_wcnt = 0; p_first_hist = 1;
    for (int i = 0; i < tpd_pkg::HIST_BINS; i++) begin
      prev_cnt[i] = '0;
      bin_total[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    enq_byte(8'h12);
    enq_byte(8'hff);
    enq_byte(8'h00);
    push_bytes(8'hff, 2);
    push_packet(tpd_pkg::TYPE_SYNC, 0, 16'd2, 0);
    push_packet(tpd_pkg::TYPE_HIST, 1, 16'd0, 0);
    push_packet(tpd_pkg::TYPE_HIST, 1, 16'd4, 1);
    push_packet(tpd_pkg::TYPE_HIST, 1, 16'd4, 2);
    push_packet(16'h0000, 1, 16'd1, 1);
    push_packet(16'hfffd, 1, 16'd3, 0);

    wait (byte_q.size() == 0);
    hold_send = 1'b1;
    wait (expect_q.size() == 0 && !in_tvalid);
    repeat (6) @(posedge clk);
    hold_send = 1'b0;

    while (rand_bytes < 900) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
        push_packet(tpd_pkg::TYPE_HIST, 1, ($urandom_range(0, 9) == 0) ?
                    16'($urandom_range(tpd_pkg::HIST_BINS - 2, tpd_pkg::HIST_BINS + 2)) :
                    16'($urandom_range(0, 12)), $urandom_range(0, 3));
      else if (r < 85)
        push_packet(($urandom_range(0, 1) ? tpd_pkg::TYPE_SYNC : 16'($urandom)), 1,
                    16'($urandom_range(0, 6)), 0);
      else
        push_packet(16'($urandom), 1, 16'($urandom_range(0, 3)), 1);
      wait (byte_q.size() == 0);
    end

    wait (byte_q.size() == 0 && !in_tvalid);
    wait (expect_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expect_q.size() == 0)
      $display("telemetry_packet_deframer_hist_delta verification clean");
    else
      $display("telemetry_packet_deframer_hist_delta verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("telemetry_packet_deframer_hist_delta verification failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ telemetry_packet_deframer_hist_delta.f @@
sv/tpd_pkg.sv
sv/tpd_ram.sv
sv/tpd_front.sv
sv/tpd_queue.sv
sv/tpd_back.sv
sv/telemetry_packet_deframer_hist_delta.sv
tb/telemetry_packet_deframer_hist_delta_tb.sv
